// ----- hdl/sps_pkg.sv -----
package sps_pkg;

    localparam int PIXEL_W   = 8;
    localparam int COORD_W   = 9;
    localparam int DIM_W     = 10;
    localparam int SAMPLE_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS   = 2'd2;

    localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 10'd512;
    localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 10'd512;
    localparam logic [SAMPLE_W-1:0] MAX_POINTS_RST   = 7'd64;

    typedef logic [PIXEL_W-1:0]  t_pixel;
    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [DIM_W-1:0]    t_dim;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

endpackage

// ----- hdl/sps_if.sv -----
interface sps_pixel_if;
    logic            valid;
    logic            ready;
    sps_pkg::t_pixel pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface sps_result_if;
    logic            valid;
    logic            ready;
    sps_pkg::t_coord point_x;
    sps_pkg::t_coord point_y;
    logic            point_valid;
    logic            last_point;

    modport source (output valid, output point_x, output point_y, output point_valid,
                    output last_point, input ready);
    modport sink (input valid, input point_x, input point_y, input point_valid,
                  input last_point, output ready);
endinterface

interface sps_cfg_if;
    logic              valid;
    logic              ready;
    sps_pkg::t_cfg_idx index;
    sps_pkg::t_dim     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/structure_point_sampler_unit.sv -----
// Structure point sampler. Pixels of a response frame arrive in raster order at one per
// cycle, and the column and row of every nonzero pixel are appended to a single-port point
// store of MAX_WIDTH*MAX_HEIGHT entries (a fill count tracks it, so there is no clearing pass
// after reset). On the last pixel of a frame the pixel input stalls while the sampled points
// are sent. When more points were stored than max_points (and max_points is above one), a
// bit-serial divider first works through each bit of the point count to find the sampling
// step. Each result then passes through the store read and the load of the output register,
// and output backpressure can hold it. An empty frame, or max_points of zero, gives one
// result with point_valid low. Configuration writes are always taken and act at once.
module structure_point_sampler_unit #(
    parameter int MAX_WIDTH   = 512,
    parameter int MAX_HEIGHT  = 512,
    parameter int MAX_SAMPLES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sps_pixel_if.sink   i_pixel,
    sps_cfg_if.sink     i_cfg,
    sps_result_if.source o_result
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = $clog2(DEPTH + 1);
    localparam int KW     = $clog2(PW + 1);
    localparam int EW     = CW + RW;
    localparam int SW     = sps_pkg::SAMPLE_W;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]    r_state, n_state;
    sps_pkg::t_dim r_frame_width;
    sps_pkg::t_dim r_frame_height;
    logic [SW-1:0] r_max_points;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [PW-1:0] r_count, n_count;
    logic [PW-1:0] r_n, n_n;
    logic [SW-1:0] r_total, n_total;
    logic [SW-1:0] r_i, n_i;
    logic [SW-1:0] r_dm1, n_dm1;
    logic          r_direct, n_direct;
    logic          r_empty, n_empty;
    logic [PW-1:0] r_q, n_q;
    logic [SW:0]   r_rem, n_rem;
    logic [PW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_div_rem, n_div_rem;
    logic [KW-1:0] r_div_cnt, n_div_cnt;

    logic                 r_o_valid, n_o_valid;
    sps_pkg::t_coord      r_o_x, n_o_x;
    sps_pkg::t_coord      r_o_y, n_o_y;
    logic                 r_o_pv, n_o_pv;
    logic                 r_o_last, n_o_last;

    logic [EW-1:0] r_store [DEPTH];
    logic [EW-1:0] r_rd_data;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [SW-1:0] m_eff;
    logic          pix_acc;
    logic          wr_en;
    logic          col_last;
    logic          row_last;
    logic [PW-1:0] count_after;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] idx;
    logic [SW+1:0] div_sh;
    logic          div_ge;
    logic [SW+1:0] step_sum;
    logic [SW+1:0] den;
    logic          out_free;
    logic          is_last;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
        if (32'(r_max_points) > MAX_SAMPLES) begin
            m_eff = SW'(MAX_SAMPLES);
        end else begin
            m_eff = r_max_points;
        end
    end

    assign pix_acc     = i_pixel.valid && i_pixel.ready;
    assign wr_en       = pix_acc && (i_pixel.pixel_value != '0) && (r_count < PW'(DEPTH));
    assign count_after = r_count + PW'(wr_en);
    assign col_last    = ((WW + 1)'(r_col) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
    assign row_last    = ((HW + 1)'(r_row) + (HW + 1)'(1)) >= (HW + 1)'(h_eff);

    assign div_sh   = {1'b0, r_div_rem, r_quo[PW-1]};
    assign div_ge   = div_sh >= (SW + 2)'(r_dm1);
    assign den      = (SW + 2)'({r_dm1, 1'b0});
    assign step_sum = (SW + 2)'(r_rem) + (SW + 2)'({r_div_rem, 1'b0});

    assign idx      = (r_q > r_n - PW'(1)) ? r_n - PW'(1) : r_q;
    assign rd_en    = (r_state == ST_READ);
    assign rd_addr  = r_direct ? AW'(r_i) : AW'(idx);
    assign out_free = !r_o_valid || o_result.ready;
    assign is_last  = r_empty || ((r_i + SW'(1)) == r_total);

    assign i_pixel.ready = (r_state == ST_RUN);
    assign i_cfg.ready   = 1'b1;

    assign o_result.valid       = r_o_valid;
    assign o_result.point_x     = r_o_x;
    assign o_result.point_y     = r_o_y;
    assign o_result.point_valid = r_o_pv;
    assign o_result.last_point  = r_o_last;

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_count   = r_count;
        n_n       = r_n;
        n_total   = r_total;
        n_i       = r_i;
        n_dm1     = r_dm1;
        n_direct  = r_direct;
        n_empty   = r_empty;
        n_q       = r_q;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_div_rem = r_div_rem;
        n_div_cnt = r_div_cnt;
        n_o_valid = r_o_valid && !o_result.ready;
        n_o_x     = r_o_x;
        n_o_y     = r_o_y;
        n_o_pv    = r_o_pv;
        n_o_last  = r_o_last;

        unique case (r_state)
            ST_RUN: begin
                if (pix_acc) begin
                    n_count = count_after;
                    if (col_last) begin
                        n_col = '0;
                        if (row_last) begin
                            n_row     = '0;
                            n_count   = '0;
                            n_n       = count_after;
                            n_i       = '0;
                            n_q       = '0;
                            n_empty   = 1'b0;
                            n_direct  = 1'b1;
                            n_dm1     = m_eff - SW'(1);
                            n_rem     = (SW + 1)'(m_eff - SW'(1));
                            n_quo     = count_after - PW'(1);
                            n_div_rem = '0;
                            n_div_cnt = KW'(PW);
                            if (count_after == '0 || m_eff == '0) begin
                                n_empty = 1'b1;
                                n_total = SW'(1);
                                n_state = ST_LOAD;
                            end else if (32'(count_after) <= 32'(m_eff)) begin
                                n_total = SW'(count_after);
                                n_state = ST_READ;
                            end else if (m_eff == SW'(1)) begin
                                n_total = SW'(1);
                                n_state = ST_READ;
                            end else begin
                                n_direct = 1'b0;
                                n_total  = m_eff;
                                n_state  = ST_DIV;
                            end
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            ST_DIV: begin
                n_quo     = PW'({r_quo, div_ge});
                n_div_rem = div_ge ? SW'(div_sh - (SW + 2)'(r_dm1)) : SW'(div_sh);
                n_div_cnt = r_div_cnt - KW'(1);
                if (r_div_cnt == KW'(1)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_pv    = !r_empty;
                    n_o_last  = is_last;
                    if (r_empty) begin
                        n_o_x = '0;
                        n_o_y = '0;
                    end else begin
                        n_o_x = sps_pkg::COORD_W'(r_rd_data[CW-1:0]);
                        n_o_y = sps_pkg::COORD_W'(r_rd_data[EW-1:CW]);
                    end
                    if (is_last) begin
                        n_state = ST_RUN;
                    end else begin
                        n_i     = r_i + SW'(1);
                        n_state = ST_READ;
                        if (step_sum >= den) begin
                            n_rem = (SW + 1)'(step_sum - den);
                            n_q   = r_q + r_quo + PW'(1);
                        end else begin
                            n_rem = (SW + 1)'(step_sum);
                            n_q   = r_q + r_quo;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_RUN;
            r_frame_width  <= sps_pkg::FRAME_WIDTH_RST;
            r_frame_height <= sps_pkg::FRAME_HEIGHT_RST;
            r_max_points   <= sps_pkg::MAX_POINTS_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_count        <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    sps_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data;
                    sps_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data;
                    sps_pkg::CFG_MAX_POINTS:   r_max_points   <= SW'(i_cfg.data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_total   <= n_total;
        r_i       <= n_i;
        r_dm1     <= n_dm1;
        r_direct  <= n_direct;
        r_empty   <= n_empty;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div_rem <= n_div_rem;
        r_div_cnt <= n_div_cnt;
        r_o_x     <= n_o_x;
        r_o_y     <= n_o_y;
        r_o_pv    <= n_o_pv;
        r_o_last  <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[AW'(r_count)] <= {r_row, r_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

endmodule
